>>> design/rfo_pkg.sv
// ----------------------------------------------------------------------------
// rfo_pkg
// Shared types and constants of the rectangle fill and outline rasterizer:
// command codes, style bytes, register indexes and the item structs.
// ----------------------------------------------------------------------------
package rfo_pkg;

   localparam int COORD_W   = 19;
   localparam int DIM_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;

   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [7:0] STYLE_FILL    = 8'h52;
   localparam logic [7:0] STYLE_OUTLINE = 8'h72;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 2'd2;

   localparam logic [8:0] WIDTH_RESET      = 9'd256;
   localparam logic [8:0] HEIGHT_RESET     = 9'd256;
   localparam logic [7:0] BACKGROUND_RESET = 8'd32;

   typedef struct packed {
      logic [1:0]                op;
      logic                      rejected;
      logic                      outline;
      logic signed [COORD_W-1:0] x_lo;
      logic signed [COORD_W:0]   x_hi;
      logic signed [COORD_W-1:0] y_lo;
      logic signed [COORD_W:0]   y_hi;
      logic [7:0]                paint;
      logic [7:0]                col;
      logic [7:0]                row;
   } cmd_type;

   typedef struct packed {
      logic [8:0] width;
      logic [8:0] height;
      logic [7:0] background;
   } cfg_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       rejected;
      logic       any_error;
   } rsp_type;

endpackage

>>> design/rfo_fifo.sv
// ----------------------------------------------------------------------------
// rfo_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rfo_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] rdata,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wptr_ff] <= wdata;
      end
   end

endmodule

>>> design/rfo_front.sv
// ----------------------------------------------------------------------------
// rfo_front
// Input stage: takes items, checks draw validity, forms the right and bottom
// edges and holds the classified command until the queue takes it.
// ----------------------------------------------------------------------------
module rfo_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [1:0]                       req_op,
   input  logic [7:0]                       req_style,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_x,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_y,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_w,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_h,
   input  logic [7:0]                       req_paint,
   input  logic [7:0]                       req_pixel_col,
   input  logic [7:0]                       req_pixel_row,
   output logic                             cmd_valid,
   output rfo_pkg::cmd_type                 cmd,
   input  logic                             cmd_full
);
   import rfo_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;
   logic    bad_style, bad_size;

   assign full      = valid_ff && cmd_full;
   assign take      = push && !full;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   assign bad_style = (req_style != STYLE_FILL) && (req_style != STYLE_OUTLINE);
   assign bad_size  = req_rect_w[COORD_W-1] || (req_rect_w == '0) ||
                      req_rect_h[COORD_W-1] || (req_rect_h == '0);

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (valid_ff && !cmd_full) begin
         valid_in = 1'b0;
      end
      cmd_in.op       = req_op;
      cmd_in.rejected = (req_op == OP_DRAW) && (bad_style || bad_size);
      cmd_in.outline  = (req_style == STYLE_OUTLINE);
      cmd_in.x_lo     = req_rect_x;
      cmd_in.x_hi     = {req_rect_x[COORD_W-1], req_rect_x} +
                        {req_rect_w[COORD_W-1], req_rect_w};
      cmd_in.y_lo     = req_rect_y;
      cmd_in.y_hi     = {req_rect_y[COORD_W-1], req_rect_y} +
                        {req_rect_h[COORD_W-1], req_rect_h};
      cmd_in.paint    = req_paint;
      cmd_in.col      = req_pixel_col;
      cmd_in.row      = req_pixel_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

>>> design/rfo_back.sv
// ----------------------------------------------------------------------------
// rfo_back
// Execution engine: owns the canvas memory, sweeps it for draw and clear,
// reads single pixels and keeps the sticky error flag.
// ----------------------------------------------------------------------------
module rfo_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  rfo_pkg::cfg_type cfg,
   input  logic             cmd_empty,
   input  rfo_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   output rfo_pkg::rsp_type rsp,
   input  logic             rsp_full
);
   import rfo_pkg::*;

   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW  = (CW > RW) ? CW : RW;
   localparam int PW  = (AW + FRAC_BITS + 2 > COORD_W + 3) ? AW + FRAC_BITS + 2 : COORD_W + 3;
   localparam int MEM_DEPTH = 1 << (CW + RW);
   localparam logic signed [PW-1:0] ONE =
      {{(PW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_SWEEP = 5'b00100,
      ST_READ  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               cur_ff, cur_in;
   logic                  clear_ff, clear_in;
   logic                  error_ff, error_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;
   logic signed [PW-1:0]  xlo_ff, xhi_ff, xlo1_ff, xhi1_ff;
   logic signed [PW-1:0]  ylo_ff, yhi_ff, ylo1_ff, yhi1_ff;
   logic signed [PW-1:0]  px, py;
   logic signed [PW-1:0]  xlo_ext, xhi_ext, ylo_ext, yhi_ext;

   logic [DIM_W-1:0]      wid, hei, lim_w, lim_h;
   logic [DIM_W-1:0]      width_ext, height_ext, col_ext, row_ext;
   logic [DIM_W-1:0]      rd_col_ext, rd_row_ext;
   logic                  rd_ok, last_col, last_row;
   logic                  in_x, in_y, on_edge, paint_hit;

   logic [7:0]            mem [MEM_DEPTH];
   logic [7:0]            rd_q;
   logic                  we;
   logic [7:0]            wdata;
   logic [CW+RW-1:0]      waddr, raddr;

   assign width_ext  = {{(DIM_W - 9){1'b0}}, cfg.width};
   assign height_ext = {{(DIM_W - 9){1'b0}}, cfg.height};
   assign wid = (width_ext == '0) ? DIM_W'(1) :
                (width_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ext;
   assign hei = (height_ext == '0) ? DIM_W'(1) :
                (height_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ext;
   assign lim_w = clear_ff ? DIM_W'(MAX_WIDTH) : wid;
   assign lim_h = clear_ff ? DIM_W'(MAX_HEIGHT) : hei;

   assign col_ext  = {{(DIM_W - CW){1'b0}}, col_ff};
   assign row_ext  = {{(DIM_W - RW){1'b0}}, row_ff};
   assign last_col = (col_ext == lim_w - 1'b1);
   assign last_row = (row_ext == lim_h - 1'b1);

   assign rd_col_ext = {{(DIM_W - 8){1'b0}}, cur_ff.col};
   assign rd_row_ext = {{(DIM_W - 8){1'b0}}, cur_ff.row};
   assign rd_ok      = (rd_col_ext < wid) && (rd_row_ext < hei);
   assign raddr      = {rd_row_ext[RW-1:0], rd_col_ext[CW-1:0]};

   assign xlo_ext = {{(PW - COORD_W){cur_ff.x_lo[COORD_W-1]}}, cur_ff.x_lo};
   assign xhi_ext = {{(PW - COORD_W - 1){cur_ff.x_hi[COORD_W]}}, cur_ff.x_hi};
   assign ylo_ext = {{(PW - COORD_W){cur_ff.y_lo[COORD_W-1]}}, cur_ff.y_lo};
   assign yhi_ext = {{(PW - COORD_W - 1){cur_ff.y_hi[COORD_W]}}, cur_ff.y_hi};

   assign px = {{(PW - CW - FRAC_BITS){1'b0}}, col_ff, {FRAC_BITS{1'b0}}};
   assign py = {{(PW - RW - FRAC_BITS){1'b0}}, row_ff, {FRAC_BITS{1'b0}}};

   assign in_x      = (px >= xlo_ff) && (px <= xhi_ff);
   assign in_y      = (py >= ylo_ff) && (py <= yhi_ff);
   assign on_edge   = (px < xlo1_ff) || (px > xhi1_ff) || (py < ylo1_ff) || (py > yhi1_ff);
   assign paint_hit = in_x && in_y && (!cur_ff.outline || on_edge);

   assign we    = (state_ff == ST_SWEEP) && (clear_ff || paint_hit);
   assign wdata = clear_ff ? cfg.background : cur_ff.paint;
   assign waddr = {row_ff, col_ff};

   assign cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty;
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp.pixel     = ((cur_ff.op == OP_READ) && rd_ok) ? rd_q : 8'd0;
   assign rsp.rejected  = (cur_ff.op == OP_DRAW) && cur_ff.rejected;
   assign rsp.any_error = error_ff;

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      clear_in = clear_ff;
      error_in = error_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cur_in   = cmd;
               clear_in = 1'b0;
               col_in   = '0;
               row_in   = '0;
               case (cmd.op)
                  OP_DRAW: begin
                     if (cmd.rejected) begin
                        error_in = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SETUP;
                     end
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     clear_in = 1'b1;
                     error_in = 1'b0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  state_in = ST_DONE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         clear_ff <= 1'b0;
         error_ff <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         error_ff <= error_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (state_ff == ST_SETUP) begin
         xlo_ff  <= xlo_ext;
         xhi_ff  <= xhi_ext;
         xlo1_ff <= xlo_ext + ONE;
         xhi1_ff <= xhi_ext - ONE;
         ylo_ff  <= ylo_ext;
         yhi_ff  <= yhi_ext;
         ylo1_ff <= ylo_ext + ONE;
         yhi1_ff <= yhi_ext - ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_q <= mem[raddr];
   end

endmodule

>>> design/rect_fill_outline_rasterizer_top.sv
// ----------------------------------------------------------------------------
// rect_fill_outline_rasterizer_top
// Byte canvas with rectangle fill/outline drawing, pixel read and clear.
// Draw sweeps the W*H canvas and clear the whole MAX_WIDTH*MAX_HEIGHT memory,
// one pixel per cycle over the canvas memory port.
// Only one item is in the engine at a time; up to three more wait in the
// input register and the queue.
// Reset: synchronous; clears queues, error flag and registers to their
// defaults; canvas contents stay undefined until a clear or draw writes them.
// ----------------------------------------------------------------------------
module rect_fill_outline_rasterizer_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [1:0]                         req_op,
   input  logic [7:0]                         req_style,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_x,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_y,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_w,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_h,
   input  logic [7:0]                         req_paint,
   input  logic [7:0]                         req_pixel_col,
   input  logic [7:0]                         req_pixel_row,
   output logic                               empty,
   input  logic                               pop,
   output logic [7:0]                         rsp_pixel,
   output logic                               rsp_rejected,
   output logic                               rsp_any_error,
   input  logic                               csr_wr_en,
   input  logic [rfo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rfo_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import rfo_pkg::*;

   cfg_type cfg_ff;
   logic    front_valid;
   cmd_type front_cmd;
   logic    cmdq_full, cmdq_empty, cmdq_pop;
   cmd_type cmdq_data;
   logic    res_valid, resq_full;
   rsp_type res_data, resq_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width      <= WIDTH_RESET;
         cfg_ff.height     <= HEIGHT_RESET;
         cfg_ff.background <= BACKGROUND_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH:      cfg_ff.width      <= csr_wdata;
            CSR_HEIGHT:     cfg_ff.height     <= csr_wdata;
            CSR_BACKGROUND: cfg_ff.background <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   rfo_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_op        (req_op),
      .req_style     (req_style),
      .req_rect_x    (req_rect_x),
      .req_rect_y    (req_rect_y),
      .req_rect_w    (req_rect_w),
      .req_rect_h    (req_rect_h),
      .req_paint     (req_paint),
      .req_pixel_col (req_pixel_col),
      .req_pixel_row (req_pixel_row),
      .cmd_valid     (front_valid),
      .cmd           (front_cmd),
      .cmd_full      (cmdq_full)
   );

   rfo_fifo #(
      .DATA_W ($bits(cmd_type)),
      .DEPTH  (2)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (front_valid),
      .wdata (front_cmd),
      .full  (cmdq_full),
      .pop   (cmdq_pop),
      .rdata (cmdq_data),
      .empty (cmdq_empty)
   );

   rfo_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmdq_empty),
      .cmd       (cmdq_data),
      .cmd_pop   (cmdq_pop),
      .rsp_valid (res_valid),
      .rsp       (res_data),
      .rsp_full  (resq_full)
   );

   rfo_fifo #(
      .DATA_W ($bits(rsp_type)),
      .DEPTH  (2)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_valid),
      .wdata (res_data),
      .full  (resq_full),
      .pop   (pop),
      .rdata (resq_data),
      .empty (empty)
   );

   assign rsp_pixel     = resq_data.pixel;
   assign rsp_rejected  = resq_data.rejected;
   assign rsp_any_error = resq_data.any_error;

endmodule

>>> dv/rfo_canvas_checker.sv
// ----------------------------------------------------------------------------
// rfo_canvas_checker
// Watches the command, result and register channels of the rasterizer. It
// keeps its own canvas, sticky error flag and register copies, works out
// the result of every accepted command and compares each accepted result,
// field by field, with the oldest expected one. It reports the mismatch
// count and the number of results still owed.
// ----------------------------------------------------------------------------
module rfo_canvas_checker #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic                               full,
   input  logic [1:0]                         req_op,
   input  logic [7:0]                         req_style,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_x,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_y,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_w,
   input  logic signed [rfo_pkg::COORD_W-1:0] req_rect_h,
   input  logic [7:0]                         req_paint,
   input  logic [7:0]                         req_pixel_col,
   input  logic [7:0]                         req_pixel_row,
   input  logic                               empty,
   input  logic                               pop,
   input  logic [7:0]                         rsp_pixel,
   input  logic                               rsp_rejected,
   input  logic                               rsp_any_error,
   input  logic                               csr_wr_en,
   input  logic [rfo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rfo_pkg::CSR_DAT_W-1:0]      csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding
);
   import rfo_pkg::*;

   localparam longint UNIT = longint'(1) << FRAC_BITS;

   logic [7:0] canvas_model [0:MAX_WIDTH*MAX_HEIGHT-1];
   logic       error_sticky;
   logic [8:0] cols_reg;
   logic [8:0] rows_reg;
   logic [7:0] bg_reg;
   rsp_type    expected_rsp [$];

   task automatic predict_result();
      rsp_type want;
      int      cols;
      int      rows;
      longint  x0, y0, x1, y1, w0, h0, px, py;
      want = '0;
      cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_WIDTH) ? MAX_WIDTH : int'(cols_reg);
      rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_reg);
      case (req_op)
         OP_DRAW: begin
            x0 = req_rect_x;
            y0 = req_rect_y;
            w0 = req_rect_w;
            h0 = req_rect_h;
            x1 = x0 + w0;
            y1 = y0 + h0;
            if (w0 <= 0 || h0 <= 0 ||
                (req_style != STYLE_FILL && req_style != STYLE_OUTLINE)) begin
               want.rejected = 1'b1;
               error_sticky = 1'b1;
            end else begin
               for (int r = 0; r < rows; r++) begin
                  py = longint'(r) << FRAC_BITS;
                  if (py < y0 || py > y1)
                     continue;
                  for (int c = 0; c < cols; c++) begin
                     px = longint'(c) << FRAC_BITS;
                     if (px < x0 || px > x1)
                        continue;
                     if (req_style == STYLE_OUTLINE &&
                         !(px - x0 < UNIT || x1 - px < UNIT ||
                           py - y0 < UNIT || y1 - py < UNIT))
                        continue;
                     canvas_model[r*MAX_WIDTH + c] = req_paint;
                  end
               end
            end
         end
         OP_READ: begin
            if (req_pixel_col < cols && req_pixel_row < rows)
               want.pixel = canvas_model[int'(req_pixel_row)*MAX_WIDTH + int'(req_pixel_col)];
         end
         OP_CLEAR: begin
            for (int i = 0; i < MAX_WIDTH*MAX_HEIGHT; i++)
               canvas_model[i] = bg_reg;
            error_sticky = 1'b0;
         end
         default: ;
      endcase
      want.any_error = error_sticky;
      expected_rsp.push_back(want);
   endtask

   task automatic check_result();
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: pixel %h rejected %b any_error %b",
                     rsp_pixel, rsp_rejected, rsp_any_error);
      end else begin
         want = expected_rsp.pop_front();
         if (rsp_pixel !== want.pixel || rsp_rejected !== want.rejected ||
             rsp_any_error !== want.any_error) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: pixel exp %h got %h, rejected exp %b got %b, any_error exp %b got %b",
                        want.pixel, rsp_pixel, want.rejected, rsp_rejected,
                        want.any_error, rsp_any_error);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         error_sticky = 1'b0;
         cols_reg     = WIDTH_RESET;
         rows_reg     = HEIGHT_RESET;
         bg_reg       = BACKGROUND_RESET;
         mismatches   = 0;
         expected_rsp.delete();
      end else begin
         if (pop && !empty)
            check_result();
         if (push && !full)
            predict_result();
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WIDTH:      cols_reg = csr_wdata;
               CSR_HEIGHT:     rows_reg = csr_wdata;
               CSR_BACKGROUND: bg_reg   = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_rsp.size();
   end

endmodule

>>> dv/tb_rect_fill_outline_rasterizer_top.sv
// ----------------------------------------------------------------------------
// tb_rect_fill_outline_rasterizer_top
// Drives the rasterizer with a directed command list (corner reads, fill and
// outline draws, rejected draws of bad style, zero or negative width or
// negative height, no-op, reads off the canvas, clear of the sticky error)
// and random command phases over several canvas sizes and backgrounds, with
// random gaps on both channels; the canvas checker beside the block checks.
// ----------------------------------------------------------------------------
module tb_rect_fill_outline_rasterizer_top;
   import rfo_pkg::*;

   localparam int                   MAX_DIM     = 256;
   localparam int                   PX          = 256;
   localparam logic [1:0]           OP_NOP      = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam int                   CYCLE_LIMIT = 4_000_000;

   logic                      clock;
   logic                      reset         = 1'b1;
   logic                      push          = 1'b0;
   logic                      full;
   logic [1:0]                req_op        = '0;
   logic [7:0]                req_style     = '0;
   logic signed [COORD_W-1:0] req_rect_x    = '0;
   logic signed [COORD_W-1:0] req_rect_y    = '0;
   logic signed [COORD_W-1:0] req_rect_w    = '0;
   logic signed [COORD_W-1:0] req_rect_h    = '0;
   logic [7:0]                req_paint     = '0;
   logic [7:0]                req_pixel_col = '0;
   logic [7:0]                req_pixel_row = '0;
   logic                      empty;
   logic                      pop           = 1'b0;
   logic [7:0]                rsp_pixel;
   logic                      rsp_rejected;
   logic                      rsp_any_error;
   logic                      csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index     = '0;
   logic [CSR_DAT_W-1:0]      csr_wdata     = '0;

   int mismatches;
   int outstanding;
   int tx_idle_pct = 21;
   int rx_idle_pct = 45;
   int eff_w       = MAX_DIM;
   int eff_h       = MAX_DIM;
   int cycle_count = 0;

   rect_fill_outline_rasterizer_top uut (.*);

   rfo_canvas_checker canvas_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock)
      pop <= !reset && ($urandom_range(0, 99) >= rx_idle_pct);

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] style,
                            input logic signed [COORD_W-1:0] x, y, w, h,
                            input logic [7:0] paint, col, row);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push          <= 1'b1;
      req_op        <= op;
      req_style     <= style;
      req_rect_x    <= x;
      req_rect_y    <= y;
      req_rect_w    <= w;
      req_rect_h    <= h;
      req_paint     <= paint;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic drain();
      push <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [8:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_WIDTH)
         eff_w = (data == 0) ? 1 : (data > MAX_DIM) ? MAX_DIM : int'(data);
      if (idx == CSR_HEIGHT)
         eff_h = (data == 0) ? 1 : (data > MAX_DIM) ? MAX_DIM : int'(data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_item();
      int         pick;
      int         xv, yv, wv, hv;
      logic [7:0] sty;
      logic [7:0] col;
      logic [7:0] row;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: sty = STYLE_FILL;
            4, 5, 6, 7: sty = STYLE_OUTLINE;
            default:    sty = $urandom_range(0, 255);
         endcase
         xv = $urandom_range(0, (eff_w + 2) * PX);
         xv -= 2 * PX;
         yv = $urandom_range(0, (eff_h + 2) * PX);
         yv -= 2 * PX;
         wv = $urandom_range(1, (eff_w + 1) * PX);
         hv = $urandom_range(1, (eff_h + 1) * PX);
         case ($urandom_range(0, 19))
            0: wv = 0 - int'($urandom_range(0, 4 * PX));
            1: hv = 0 - int'($urandom_range(0, 4 * PX));
            2, 3: begin
               xv = $urandom;
               yv = $urandom;
               wv = $urandom;
               hv = $urandom;
            end
            default: ;
         endcase
         send_item(OP_DRAW, sty, xv, yv, wv, hv, $urandom_range(0, 255),
                   $urandom, $urandom);
      end else if (pick < 94) begin
         if ($urandom_range(0, 3) != 0) begin
            col = $urandom_range(0, eff_w - 1);
            row = $urandom_range(0, eff_h - 1);
         end else begin
            col = $urandom_range(0, 255);
            row = $urandom_range(0, 255);
         end
         send_item(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, col, row);
      end else begin
         send_item(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
      end
   endtask

   task automatic random_phase(input int count);
      int clear_slot;
      clear_slot = $urandom_range(0, count - 1);
      for (int i = 0; i < count; i++) begin
         if (i == clear_slot)
            send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
         else
            random_item();
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full-size canvas: corners and the far edge
      send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(OP_DRAW, STYLE_OUTLINE, 200 * PX + 128, 240 * PX, 55 * PX + 128,
                15 * PX + 128, 8'h23, 0, 0);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 255, 255);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 201, 250);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      drain();

      write_reg(CSR_WIDTH, 12);
      write_reg(CSR_HEIGHT, 9);
      write_reg(CSR_BACKGROUND, 8'h2E);
      send_item(OP_DRAW, STYLE_FILL, 2 * PX + 128, PX, 3 * PX, 2 * PX + 128, 8'h41, 0, 0);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 3, 1);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 5, 3);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 2, 1);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 6, 2);
      send_item(OP_DRAW, STYLE_OUTLINE, PX, PX, 6 * PX + 64, 5 * PX, 8'h6F, 0, 0);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 7, 3);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 4, 3);
      send_item(OP_DRAW, STYLE_FILL, 0, 0, 0, PX, 8'h55, 0, 0);
      send_item(OP_DRAW, STYLE_OUTLINE, 0, 0, PX, -1, 8'h55, 0, 0);
      send_item(OP_DRAW, 8'h78, 0, 0, PX, PX, 8'h55, 0, 0);
      send_item(OP_DRAW, STYLE_FILL, 0, 0, -262144, 262143, 8'h55, 0, 0);
      send_item(OP_DRAW, STYLE_FILL, 262143, 262143, 262143, 262143, 8'hAA, 0, 0);
      send_item(OP_DRAW, STYLE_FILL, -262144, -262144, 262143, 262143, 8'hAA, 0, 0);
      send_item(OP_DRAW, 8'hFF, 0, 0, PX, PX, 8'h00, 0, 0);
      send_item(OP_NOP, 8'hFF, -1, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 200, 2);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 2, 200);
      send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(OP_READ, 0, 0, 0, 0, 0, 0, 3, 3);
      drain();

      write_reg(CSR_WIDTH, 16);
      write_reg(CSR_HEIGHT, 12);
      write_reg(CSR_BACKGROUND, $urandom_range(0, 255));
      random_phase(20);
      drain();

      tx_idle_pct = 45;
      rx_idle_pct = 21;
      write_reg(CSR_WIDTH, 0);
      write_reg(CSR_HEIGHT, 300);
      write_reg(CSR_BACKGROUND, 8'hFF);
      random_phase(15);
      drain();

      write_reg(CSR_WIDTH, 511);
      write_reg(CSR_HEIGHT, 0);
      write_reg(CSR_BACKGROUND, 8'h00);
      random_phase(15);
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_reg(CSR_UNUSED, 9'h1A5);
      write_reg(CSR_WIDTH, 20);
      write_reg(CSR_HEIGHT, 20);
      write_reg(CSR_BACKGROUND, $urandom_range(0, 255));
      random_phase(20);
      drain();
      repeat (20) @(negedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
